// File: sv/tcp_connection_endpoint_core_assert.svh
// Assertion macros for the TCP connection endpoint core.
// Needs nothing else; the macros are empty when SYNTH is defined.
`ifndef TCP_CONNECTION_ENDPOINT_CORE_ASSERT_SVH
`define TCP_CONNECTION_ENDPOINT_CORE_ASSERT_SVH
`ifndef SYNTH
`define TCE_ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tce check failed");
`define TCE_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tce check failed");
`else
`define TCE_ASSERT_IMPLY(label, clk, rst, pre, post)
`define TCE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: sv/tce_pkg.sv
// Shared types and codes of the TCP connection endpoint core.
// No dependencies.
package tce_pkg;

  typedef enum logic [3:0] {
    ACT_OPEN        = 4'd0,
    ACT_LISTEN      = 4'd1,
    ACT_RX_SYN      = 4'd2,
    ACT_TX_SYN_ACK  = 4'd3,
    ACT_RX_SYN_ACK  = 4'd4,
    ACT_RX_ACK      = 4'd5,
    ACT_RX_DATA     = 4'd6,
    ACT_RX_FIN      = 4'd7,
    ACT_TX_ACK      = 4'd8,
    ACT_SEND_DATA   = 4'd9,
    ACT_COMMIT_SEND = 4'd10,
    ACT_BEGIN_CLOSE = 4'd11,
    ACT_NOTE_RETX   = 4'd12,
    ACT_SET_WINDOW  = 4'd13
  } action_t;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_BAD_STATE    = 2'd1,
    STS_MISMATCH     = 2'd2,
    STS_SEQ_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    CM_CLOSED     = 8'b0000_0001,
    CM_LISTEN     = 8'b0000_0010,
    CM_SYN_SENT   = 8'b0000_0100,
    CM_SYN_RCVD   = 8'b0000_1000,
    CM_ESTAB      = 8'b0001_0000,
    CM_FIN_WAIT1  = 8'b0010_0000,
    CM_FIN_WAIT2  = 8'b0100_0000,
    CM_CLOSE_WAIT = 8'b1000_0000
  } conn_mode_t;

  localparam logic [2:0] CODE_CLOSED     = 3'd0;
  localparam logic [2:0] CODE_LISTEN     = 3'd1;
  localparam logic [2:0] CODE_SYN_SENT   = 3'd2;
  localparam logic [2:0] CODE_SYN_RCVD   = 3'd3;
  localparam logic [2:0] CODE_ESTAB      = 3'd4;
  localparam logic [2:0] CODE_FIN_WAIT1  = 3'd5;
  localparam logic [2:0] CODE_FIN_WAIT2  = 3'd6;
  localparam logic [2:0] CODE_CLOSE_WAIT = 3'd7;

  localparam logic [5:0]  FL_FIN = 6'h01;
  localparam logic [5:0]  FL_SYN = 6'h02;
  localparam logic [5:0]  FL_ACK = 6'h10;
  localparam logic [15:0] WINDOW_FULL = 16'hffff;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] own_port;
    logic [15:0] far_port;
    logic [31:0] initial_sequence;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [5:0]  seg_flags;
    logic [15:0] length;
    logic [7:0]  retx_cap;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  conn_state;
    logic        seg_out_valid;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [5:0]  out_flags;
    logic [15:0] taken_len;
    logic        retransmit_allowed;
  } res_item_t;

  function automatic logic [2:0] mode_code(input conn_mode_t m);
    logic [2:0] c;
    case (m)
      CM_CLOSED:     c = CODE_CLOSED;
      CM_LISTEN:     c = CODE_LISTEN;
      CM_SYN_SENT:   c = CODE_SYN_SENT;
      CM_SYN_RCVD:   c = CODE_SYN_RCVD;
      CM_ESTAB:      c = CODE_ESTAB;
      CM_FIN_WAIT1:  c = CODE_FIN_WAIT1;
      CM_FIN_WAIT2:  c = CODE_FIN_WAIT2;
      CM_CLOSE_WAIT: c = CODE_CLOSE_WAIT;
      default:       c = CODE_CLOSED;
    endcase
    return c;
  endfunction

endpackage

// File: sv/tce_if.sv
// Valid/ready channel interfaces for the endpoint core: one for requests,
// one for results. Depends on tce_pkg.
interface tce_cmd_if import tce_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tce_res_if import tce_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/tcp_connection_endpoint_core.sv
// Top level of the TCP connection endpoint core: connection state, handling
// of every request and the result register. Depends on tce_pkg, tce_if.sv
// and tcp_connection_endpoint_core_assert.svh.
//
// This block keeps the control state of a single TCP connection and takes one
// request per cycle on cmd while rsp keeps up: a local command or the header
// of a received segment, chosen by the action code. Every request yields
// exactly one result on rsp, in request order, carrying a status, the
// connection state after the request and, for the commands that build a
// segment, the header fields of that segment (data offset 0x50 and window
// 65535 are implied). A request is first captured in an input register; in
// the cycle it leaves that register the whole decision is made by a single
// pass of compares and 32-bit adds against the state registers, which are
// updated at the same edge the result register is loaded. The result is
// therefore presented on rsp from the result register, which follows the
// input register. The sustained rate is one request per cycle while rsp takes
// every result, set by the single state update per cycle. While a finished
// result waits to be taken, an empty input register can still take one more
// request, so under back-pressure one request waits in each register and
// then cmd stalls. Sequence comparisons are plain unsigned, and sequence
// additions wrap modulo two to the thirty-second.
`include "tcp_connection_endpoint_core_assert.svh"

module tcp_connection_endpoint_core
  import tce_pkg::*;
(
  input logic      clk,
  input logic      rst,
  tce_cmd_if.sink  cmd,
  tce_res_if.source rsp
);

  // Input register.
  logic      a_valid;
  cmd_item_t a_item;
  // Result register.
  logic      r_valid;
  res_item_t r_item;

  // Connection state.
  conn_mode_t  conn_mode, conn_mode_next;
  logic [15:0] my_port, my_port_next;
  logic [15:0] peer_port, peer_port_next;
  logic [31:0] send_next, send_next_next;
  logic [31:0] recv_next, recv_next_next;
  logic [15:0] rx_window, rx_window_next;
  logic [15:0] pending_len, pending_len_next;
  logic [7:0]  resend_count, resend_count_next;
  logic [7:0]  resend_limit, resend_limit_next;

  logic      advance;
  res_item_t res_next;

  // The request in the input register moves on whenever the result register
  // is empty or its contents are being taken this cycle.
  assign advance   = a_valid && (!r_valid || rsp.ready);
  assign cmd.ready = !a_valid || advance;
  assign rsp.valid = r_valid;
  assign rsp.data  = r_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd.ready) begin
      a_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      a_item <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (rsp.ready) begin
      r_valid <= 1'b0;
    end
    if (advance) begin
      r_item <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_mode    <= CM_CLOSED;
      my_port      <= '0;
      peer_port    <= '0;
      send_next    <= '0;
      recv_next    <= '0;
      rx_window    <= WINDOW_FULL;
      pending_len  <= '0;
      resend_count <= '0;
      resend_limit <= '0;
    end else if (advance) begin
      conn_mode    <= conn_mode_next;
      my_port      <= my_port_next;
      peer_port    <= peer_port_next;
      send_next    <= send_next_next;
      recv_next    <= recv_next_next;
      rx_window    <= rx_window_next;
      pending_len  <= pending_len_next;
      resend_count <= resend_count_next;
      resend_limit <= resend_limit_next;
    end
  end

  // Single-pass handling of the request in the input register. A failed
  // request changes no state and builds no header.
  always_comb begin
    logic       ports_ok;
    logic       match;
    logic       has_fin;
    logic       has_syn;
    logic       has_ack;
    logic       build;
    logic [5:0] build_flags;
    status_t    sts;
    logic [31:0] len_ext;

    ports_ok    = (my_port != '0) && (peer_port != '0);
    match       = (a_item.seg_src_port == peer_port) && (a_item.seg_dst_port == my_port);
    has_fin     = (a_item.seg_flags & FL_FIN) != '0;
    has_syn     = (a_item.seg_flags & FL_SYN) != '0;
    has_ack     = (a_item.seg_flags & FL_ACK) != '0;
    build       = 1'b0;
    build_flags = '0;
    sts         = STS_OK;
    len_ext     = {16'd0, a_item.length};

    conn_mode_next    = conn_mode;
    my_port_next      = my_port;
    peer_port_next    = peer_port;
    send_next_next    = send_next;
    recv_next_next    = recv_next;
    rx_window_next    = rx_window;
    pending_len_next  = pending_len;
    resend_count_next = resend_count;
    resend_limit_next = resend_limit;

    res_next = '0;

    case (a_item.action)
      ACT_OPEN, ACT_LISTEN: begin
        if (a_item.own_port == '0 ||
            (a_item.action == ACT_OPEN && a_item.far_port == '0)) begin
          sts = STS_BAD_STATE;
        end else begin
          // A fresh connection record.
          my_port_next      = a_item.own_port;
          recv_next_next    = '0;
          pending_len_next  = '0;
          resend_count_next = '0;
          resend_limit_next = '0;
          rx_window_next    = WINDOW_FULL;
          if (a_item.action == ACT_OPEN) begin
            peer_port_next = a_item.far_port;
            send_next_next = a_item.initial_sequence + 32'd1;
            conn_mode_next = CM_SYN_SENT;
          end else begin
            peer_port_next = '0;
            send_next_next = a_item.initial_sequence;
            conn_mode_next = CM_LISTEN;
          end
        end
      end
      ACT_RX_SYN: begin
        if (conn_mode != CM_LISTEN || a_item.seg_src_port == '0 ||
            a_item.seg_dst_port != my_port || !has_syn || has_ack) begin
          sts = STS_BAD_STATE;
        end else begin
          peer_port_next = a_item.seg_src_port;
          recv_next_next = a_item.seg_seq + 32'd1;
          conn_mode_next = CM_SYN_RCVD;
        end
      end
      ACT_TX_SYN_ACK: begin
        if (conn_mode != CM_SYN_RCVD || !ports_ok) begin
          sts = STS_BAD_STATE;
        end else begin
          build       = 1'b1;
          build_flags = FL_SYN | FL_ACK;
        end
      end
      ACT_RX_SYN_ACK: begin
        if (conn_mode != CM_SYN_SENT) begin
          sts = STS_BAD_STATE;
        end else if (!ports_ok || !match || !has_syn || !has_ack ||
                     a_item.seg_ack != send_next) begin
          sts = STS_MISMATCH;
        end else begin
          recv_next_next = a_item.seg_seq + 32'd1;
          conn_mode_next = CM_ESTAB;
        end
      end
      ACT_RX_ACK: begin
        if (conn_mode != CM_ESTAB && conn_mode != CM_FIN_WAIT1 &&
            conn_mode != CM_SYN_RCVD) begin
          sts = STS_BAD_STATE;
        end else if (!match || !has_ack) begin
          sts = STS_MISMATCH;
        end else if (conn_mode == CM_SYN_RCVD) begin
          // Final step of the passive handshake.
          if (a_item.seg_seq != recv_next || a_item.seg_ack != send_next + 32'd1) begin
            sts = STS_SEQ_MISMATCH;
          end else begin
            send_next_next = send_next + 32'd1;
            conn_mode_next = CM_ESTAB;
          end
        end else if (a_item.seg_ack > send_next) begin
          sts = STS_MISMATCH;
        end else if (pending_len != '0 && a_item.seg_ack < send_next) begin
          sts = STS_SEQ_MISMATCH;
        end else begin
          pending_len_next  = '0;
          resend_count_next = '0;
          resend_limit_next = '0;
          if (conn_mode == CM_FIN_WAIT1 && a_item.seg_ack == send_next) begin
            conn_mode_next = CM_FIN_WAIT2;
          end
        end
      end
      ACT_RX_DATA: begin
        if (conn_mode != CM_ESTAB) begin
          sts = STS_BAD_STATE;
        end else if (!match || !has_ack || a_item.seg_seq != recv_next ||
                     a_item.seg_ack > send_next || a_item.length > rx_window) begin
          sts = STS_MISMATCH;
        end else begin
          res_next.taken_len = a_item.length;
          recv_next_next = recv_next + len_ext;
          rx_window_next = rx_window - a_item.length;
        end
      end
      ACT_RX_FIN: begin
        if (conn_mode != CM_ESTAB && conn_mode != CM_FIN_WAIT2) begin
          sts = STS_BAD_STATE;
        end else if (!match || !has_fin || a_item.seg_seq != recv_next) begin
          sts = STS_MISMATCH;
        end else begin
          recv_next_next = recv_next + 32'd1;
          conn_mode_next = (conn_mode == CM_FIN_WAIT2) ? CM_CLOSED : CM_CLOSE_WAIT;
        end
      end
      ACT_TX_ACK: begin
        if ((conn_mode != CM_ESTAB && conn_mode != CM_FIN_WAIT2 &&
             conn_mode != CM_CLOSE_WAIT) || !ports_ok) begin
          sts = STS_BAD_STATE;
        end else begin
          build       = 1'b1;
          build_flags = FL_ACK;
        end
      end
      ACT_SEND_DATA: begin
        if (a_item.length == '0 || conn_mode != CM_ESTAB) begin
          sts = STS_BAD_STATE;
        end else if (!ports_ok) begin
          sts = STS_MISMATCH;
        end else begin
          // The header goes out at send_next; commit_send advances it later.
          build             = 1'b1;
          build_flags       = FL_ACK;
          pending_len_next  = a_item.length;
          resend_count_next = '0;
          resend_limit_next = a_item.retx_cap;
        end
      end
      ACT_COMMIT_SEND: begin
        if (conn_mode != CM_ESTAB || a_item.length == '0) begin
          sts = STS_BAD_STATE;
        end else begin
          send_next_next = send_next + len_ext;
        end
      end
      ACT_BEGIN_CLOSE: begin
        if (conn_mode != CM_ESTAB) begin
          sts = STS_BAD_STATE;
        end else if (!ports_ok) begin
          sts = STS_MISMATCH;
        end else begin
          // The FIN carries the sequence number before it is consumed.
          build          = 1'b1;
          build_flags    = FL_FIN | FL_ACK;
          send_next_next = send_next + 32'd1;
          conn_mode_next = CM_FIN_WAIT1;
        end
      end
      ACT_NOTE_RETX: begin
        if (pending_len == '0 || resend_count >= resend_limit) begin
          sts = STS_BAD_STATE;
        end else begin
          resend_count_next = resend_count + 8'd1;
        end
      end
      ACT_SET_WINDOW: begin
        rx_window_next = a_item.length;
      end
      default: begin
        sts = STS_BAD_STATE;
      end
    endcase

    res_next.status     = sts;
    res_next.conn_state = mode_code(conn_mode_next);
    if (build) begin
      res_next.seg_out_valid = 1'b1;
      res_next.out_src_port  = my_port;
      res_next.out_dst_port  = peer_port;
      res_next.out_seq       = send_next;
      res_next.out_ack       = recv_next;
      res_next.out_flags     = build_flags;
    end
    res_next.retransmit_allowed = (pending_len_next != '0) &&
                                  (resend_count_next < resend_limit_next);
  end

  // A built header only ever comes with a successful request.
  `TCE_ASSERT_IMPLY(a_hdr_ok, clk, rst, r_valid && r_item.seg_out_valid,
                    r_item.status == STS_OK)
  // Accepted payload is only reported in the established state.
  `TCE_ASSERT_IMPLY(a_data_estab, clk, rst, r_valid && r_item.taken_len != '0,
                    r_item.status == STS_OK && r_item.conn_state == CODE_ESTAB)
  // The reported retransmit flag matches the state the result left behind.
  `TCE_ASSERT_NEXT(a_retx_state, clk, rst, advance,
                   r_item.retransmit_allowed ==
                     ((pending_len != '0) && (resend_count < resend_limit)))
  // A held request with a stalled result register blocks new requests.
  `TCE_ASSERT_IMPLY(a_hold_block, clk, rst, a_valid && r_valid && !rsp.ready,
                    !cmd.ready)

endmodule

// File: tb/sv/tb_tcp_connection_endpoint_core.sv
// Self-checking testbench for tcp_connection_endpoint_core: drives requests on cmd
// and checks every result on rsp against its own model of the connection.
// Depends on tce_pkg, tce_if.sv and the endpoint core RTL.
module tb_tcp_connection_endpoint_core import tce_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 950;
  localparam int STALL_LIMIT     = 3000;
  localparam int LONG_HOLD       = 300;
  localparam int MAX_PRINTED     = 40;

  // Holds the expected connection state and the results still owed by the block.
  class endpoint_scoreboard;
    logic [2:0]  mode;
    logic [15:0] my_port;
    logic [15:0] peer_port;
    logic [15:0] rx_window;
    logic [15:0] pending_len;
    logic [31:0] snd_nxt;
    logic [31:0] rcv_nxt;
    logic [7:0]  resend_count;
    logic [7:0]  resend_limit;
    res_item_t   expected_results[$];
    int          errors;
    int          printed;
    int          n_requests;
    int          n_checked;
    int          n_headers;
    logic [7:0]  states_seen;
    logic [3:0]  statuses_seen;

    function new();
      restart(16'd0, 16'd0, 32'd0, CODE_CLOSED);
      errors = 0;
      printed = 0;
      n_requests = 0;
      n_checked = 0;
      n_headers = 0;
      states_seen = '0;
      statuses_seen = '0;
    endfunction

    function void restart(logic [15:0] lp, logic [15:0] rp, logic [31:0] seq,
                          logic [2:0] m);
      my_port = lp;
      peer_port = rp;
      snd_nxt = seq;
      rcv_nxt = 32'd0;
      pending_len = 16'd0;
      resend_count = 8'd0;
      resend_limit = 8'd0;
      rx_window = WINDOW_FULL;
      mode = m;
    endfunction

    function bit may_resend();
      return pending_len != 16'd0 && resend_count < resend_limit;
    endfunction

    function res_item_t with_header(res_item_t r, logic [5:0] f);
      r.seg_out_valid = 1'b1;
      r.out_src_port = my_port;
      r.out_dst_port = peer_port;
      r.out_seq = snd_nxt;
      r.out_ack = rcv_nxt;
      r.out_flags = f;
      return r;
    endfunction

    // Applies one request to the model and returns the result it must produce.
    function res_item_t next_result(cmd_item_t c);
      res_item_t r;
      status_t   st;
      logic      ports_ok;
      logic      match;
      r = '0;
      st = STS_OK;
      ports_ok = (my_port != 16'd0) && (peer_port != 16'd0);
      match = (c.seg_src_port == peer_port) && (c.seg_dst_port == my_port);
      case (c.action)
        ACT_OPEN: begin
          if (c.own_port == 16'd0 || c.far_port == 16'd0) st = STS_BAD_STATE;
          else restart(c.own_port, c.far_port, c.initial_sequence + 32'd1,
                       CODE_SYN_SENT);
        end
        ACT_LISTEN: begin
          if (c.own_port == 16'd0) st = STS_BAD_STATE;
          else restart(c.own_port, 16'd0, c.initial_sequence, CODE_LISTEN);
        end
        ACT_RX_SYN: begin
          if (mode != CODE_LISTEN || c.seg_src_port == 16'd0 ||
              c.seg_dst_port != my_port || (c.seg_flags & FL_SYN) == 6'd0 ||
              (c.seg_flags & FL_ACK) != 6'd0) begin
            st = STS_BAD_STATE;
          end else begin
            peer_port = c.seg_src_port;
            rcv_nxt = c.seg_seq + 32'd1;
            mode = CODE_SYN_RCVD;
          end
        end
        ACT_TX_SYN_ACK: begin
          if (mode != CODE_SYN_RCVD || !ports_ok) st = STS_BAD_STATE;
          else r = with_header(r, FL_SYN | FL_ACK);
        end
        ACT_RX_SYN_ACK: begin
          if (mode != CODE_SYN_SENT) st = STS_BAD_STATE;
          else if (!ports_ok || !match ||
                   (c.seg_flags & (FL_SYN | FL_ACK)) != (FL_SYN | FL_ACK) ||
                   c.seg_ack != snd_nxt) begin
            st = STS_MISMATCH;
          end else begin
            rcv_nxt = c.seg_seq + 32'd1;
            mode = CODE_ESTAB;
          end
        end
        ACT_RX_ACK: begin
          if (mode != CODE_ESTAB && mode != CODE_FIN_WAIT1 && mode != CODE_SYN_RCVD)
            st = STS_BAD_STATE;
          else if (!match || (c.seg_flags & FL_ACK) == 6'd0) st = STS_MISMATCH;
          else if (mode == CODE_SYN_RCVD) begin
            if (c.seg_seq != rcv_nxt || c.seg_ack != snd_nxt + 32'd1) begin
              st = STS_SEQ_MISMATCH;
            end else begin
              snd_nxt = snd_nxt + 32'd1;
              mode = CODE_ESTAB;
            end
          end else if (c.seg_ack > snd_nxt) st = STS_MISMATCH;
          else if (pending_len != 16'd0 && c.seg_ack < snd_nxt) st = STS_SEQ_MISMATCH;
          else begin
            pending_len = 16'd0;
            resend_count = 8'd0;
            resend_limit = 8'd0;
            if (mode == CODE_FIN_WAIT1 && c.seg_ack == snd_nxt) mode = CODE_FIN_WAIT2;
          end
        end
        ACT_RX_DATA: begin
          if (mode != CODE_ESTAB) st = STS_BAD_STATE;
          else if (!match || (c.seg_flags & FL_ACK) == 6'd0 || c.seg_seq != rcv_nxt ||
                   c.seg_ack > snd_nxt || c.length > rx_window) begin
            st = STS_MISMATCH;
          end else begin
            r.taken_len = c.length;
            rcv_nxt = rcv_nxt + {16'd0, c.length};
            rx_window = rx_window - c.length;
          end
        end
        ACT_RX_FIN: begin
          if (mode != CODE_ESTAB && mode != CODE_FIN_WAIT2) st = STS_BAD_STATE;
          else if (!match || (c.seg_flags & FL_FIN) == 6'd0 || c.seg_seq != rcv_nxt)
            st = STS_MISMATCH;
          else begin
            rcv_nxt = rcv_nxt + 32'd1;
            mode = (mode == CODE_FIN_WAIT2) ? CODE_CLOSED : CODE_CLOSE_WAIT;
          end
        end
        ACT_TX_ACK: begin
          if ((mode != CODE_ESTAB && mode != CODE_FIN_WAIT2 && mode != CODE_CLOSE_WAIT) ||
              !ports_ok) begin
            st = STS_BAD_STATE;
          end else begin
            r = with_header(r, FL_ACK);
          end
        end
        ACT_SEND_DATA: begin
          if (c.length == 16'd0 || mode != CODE_ESTAB) st = STS_BAD_STATE;
          else if (!ports_ok) st = STS_MISMATCH;
          else begin
            r = with_header(r, FL_ACK);
            pending_len = c.length;
            resend_count = 8'd0;
            resend_limit = c.retx_cap;
          end
        end
        ACT_COMMIT_SEND: begin
          if (mode != CODE_ESTAB || c.length == 16'd0) st = STS_BAD_STATE;
          else snd_nxt = snd_nxt + {16'd0, c.length};
        end
        ACT_BEGIN_CLOSE: begin
          if (mode != CODE_ESTAB) st = STS_BAD_STATE;
          else if (!ports_ok) st = STS_MISMATCH;
          else begin
            r = with_header(r, FL_FIN | FL_ACK);
            snd_nxt = snd_nxt + 32'd1;
            mode = CODE_FIN_WAIT1;
          end
        end
        ACT_NOTE_RETX: begin
          if (!may_resend()) st = STS_BAD_STATE;
          else resend_count = resend_count + 8'd1;
        end
        ACT_SET_WINDOW: rx_window = c.length;
        default: st = STS_BAD_STATE;
      endcase
      r.status = st;
      r.conn_state = mode;
      r.retransmit_allowed = may_resend();
      return r;
    endfunction

    function void note_request(cmd_item_t c);
      res_item_t r;
      r = next_result(c);
      expected_results.push_back(r);
      n_requests++;
      if (r.seg_out_valid) n_headers++;
      states_seen[r.conn_state] = 1'b1;
      statuses_seen[r.status] = 1'b1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (printed < MAX_PRINTED) begin
        printed++;
        $display("mismatch at result %0d: %s got %0h wanted %0h", n_checked, what, got,
                 want);
      end
    endtask

    task check_result(res_item_t got);
      res_item_t want;
      if (expected_results.size() == 0) begin
        report("result with no request outstanding", 32'(got.conn_state), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.conn_state !== want.conn_state)
          report("conn_state", 32'(got.conn_state), 32'(want.conn_state));
        if (got.seg_out_valid !== want.seg_out_valid)
          report("seg_out_valid", 32'(got.seg_out_valid), 32'(want.seg_out_valid));
        if (got.out_src_port !== want.out_src_port)
          report("out_src_port", 32'(got.out_src_port), 32'(want.out_src_port));
        if (got.out_dst_port !== want.out_dst_port)
          report("out_dst_port", 32'(got.out_dst_port), 32'(want.out_dst_port));
        if (got.out_seq !== want.out_seq) report("out_seq", got.out_seq, want.out_seq);
        if (got.out_ack !== want.out_ack) report("out_ack", got.out_ack, want.out_ack);
        if (got.out_flags !== want.out_flags)
          report("out_flags", 32'(got.out_flags), 32'(want.out_flags));
        if (got.taken_len !== want.taken_len)
          report("taken_len", 32'(got.taken_len), 32'(want.taken_len));
        if (got.retransmit_allowed !== want.retransmit_allowed)
          report("retransmit_allowed", 32'(got.retransmit_allowed),
                 32'(want.retransmit_allowed));
      end
      n_checked++;
    endtask

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   hold_asks = 0;
  int   stall_cycles = 0;

  endpoint_scoreboard sb = new();

  tce_cmd_if cmd_ch ();
  tce_res_if rsp_ch ();

  tcp_connection_endpoint_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A request whose peer-side fields agree with the model, so that it gets
  // through the state checks; fields the action ignores stay random.
  function automatic cmd_item_t make_request(action_t a);
    cmd_item_t   c;
    int unsigned hi;
    c.action = a;
    c.own_port = 16'($urandom);
    c.far_port = 16'($urandom);
    c.initial_sequence = ($urandom_range(0, 3) == 0) ? 32'hffff_fff0 + $urandom_range(0, 15)
                                                     : $urandom;
    c.seg_src_port = sb.peer_port;
    c.seg_dst_port = sb.my_port;
    c.seg_seq = sb.rcv_nxt;
    c.seg_ack = sb.snd_nxt;
    c.seg_flags = 6'($urandom);
    c.length = 16'($urandom);
    c.retx_cap = 8'($urandom);
    case (a)
      ACT_OPEN: begin
        c.own_port = 16'($urandom_range(1, 65535));
        c.far_port = 16'($urandom_range(1, 65535));
      end
      ACT_LISTEN: c.own_port = 16'($urandom_range(1, 65535));
      ACT_RX_SYN: begin
        c.seg_src_port = 16'($urandom_range(1, 65535));
        c.seg_seq = $urandom;
        c.seg_flags = (c.seg_flags & ~FL_ACK) | FL_SYN;
      end
      ACT_RX_SYN_ACK: begin
        c.seg_seq = $urandom;
        c.seg_flags = c.seg_flags | FL_SYN | FL_ACK;
      end
      ACT_RX_ACK: begin
        c.seg_flags = c.seg_flags | FL_ACK;
        if (sb.mode == CODE_SYN_RCVD) c.seg_ack = sb.snd_nxt + 32'd1;
      end
      ACT_RX_DATA: begin
        c.seg_flags = c.seg_flags | FL_ACK;
        hi = (sb.rx_window > 16'd1500) ? 1500 : sb.rx_window;
        c.length = 16'($urandom_range(0, hi));
      end
      ACT_RX_FIN: c.seg_flags = c.seg_flags | FL_FIN | FL_ACK;
      ACT_SEND_DATA: begin
        c.length = 16'($urandom_range(1, 1500));
        c.retx_cap = 8'($urandom_range(0, 4));
      end
      ACT_COMMIT_SEND: c.length = 16'($urandom_range(1, 1500));
      default: ;
    endcase
    return c;
  endfunction

  // Picks the next step of a plausible conversation from the current state.
  function automatic action_t choose_action();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return (p == 0) ? ACT_LISTEN : ACT_OPEN;
    case (sb.mode)
      CODE_CLOSED:    return (p < 70) ? ACT_OPEN : ACT_LISTEN;
      CODE_LISTEN:    return (p < 90) ? ACT_RX_SYN : ACT_SET_WINDOW;
      CODE_SYN_SENT:  return (p < 90) ? ACT_RX_SYN_ACK : ACT_NOTE_RETX;
      CODE_SYN_RCVD:  return (p < 50) ? ACT_TX_SYN_ACK : ACT_RX_ACK;
      CODE_ESTAB: begin
        if (p < 20) return ACT_RX_DATA;
        else if (p < 30) return ACT_SET_WINDOW;
        else if (p < 45) return ACT_SEND_DATA;
        else if (p < 57) return ACT_NOTE_RETX;
        else if (p < 70) return ACT_RX_ACK;
        else if (p < 80) return ACT_COMMIT_SEND;
        else if (p < 89) return ACT_TX_ACK;
        else if (p < 95) return ACT_BEGIN_CLOSE;
        else return ACT_RX_FIN;
      end
      CODE_FIN_WAIT1: return (p < 70) ? ACT_RX_ACK : ((p < 85) ? ACT_TX_ACK : ACT_NOTE_RETX);
      CODE_FIN_WAIT2: return (p < 60) ? ACT_RX_FIN : ACT_TX_ACK;
      default:        return (p < 50) ? ACT_TX_ACK : ((p < 80) ? ACT_OPEN : ACT_LISTEN);
    endcase
  endfunction

  // Mostly well-formed conversation steps, some with one field spoiled, and
  // a share of pure noise that includes the unused action codes.
  function automatic cmd_item_t random_request();
    cmd_item_t c;
    int        p;
    p = $urandom_range(0, 99);
    if (p < 12) begin
      c = make_request(ACT_SET_WINDOW);
      c.action = 4'($urandom_range(0, 15));
      c.seg_src_port = 16'($urandom);
      c.seg_dst_port = 16'($urandom);
      c.seg_seq = $urandom;
      c.seg_ack = $urandom;
      return c;
    end
    c = make_request(choose_action());
    case (c.action)
      ACT_RX_ACK: if (sb.mode != CODE_SYN_RCVD && $urandom_range(0, 4) == 0)
        c.seg_ack = sb.snd_nxt - $urandom_range(1, 100);
      ACT_RX_DATA: begin
        if ($urandom_range(0, 6) == 0) c.seg_ack = sb.snd_nxt - $urandom_range(1, 100);
        if ($urandom_range(0, 9) == 0) c.length = sb.rx_window;
      end
      ACT_SET_WINDOW: begin
        if ($urandom_range(0, 2) == 0) c.length = WINDOW_FULL;
        else if ($urandom_range(0, 7) == 0) c.length = 16'd0;
      end
      ACT_SEND_DATA: if ($urandom_range(0, 9) == 0) c.retx_cap = 8'($urandom);
      default: ;
    endcase
    if (p < 22) begin
      case ($urandom_range(0, 5))
        0: c.seg_src_port ^= 16'($urandom_range(1, 65535));
        1: c.seg_dst_port ^= 16'($urandom_range(1, 65535));
        2: c.seg_seq ^= ($urandom | 32'd1);
        3: c.seg_ack ^= ($urandom | 32'd1);
        4: c.seg_flags ^= 6'($urandom_range(1, 63));
        default: c.length ^= 16'($urandom_range(1, 65535));
      endcase
    end
    return c;
  endfunction

  task automatic send_request(cmd_item_t c);
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sb.note_request(c);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Receiver: changes its stall style after a random run, and on request
  // holds ready low for a long stretch so that the block backs up.
  initial begin
    int hold_left;
    int holds_served;
    int style;
    int style_left;
    hold_left = 0;
    holds_served = 0;
    style = 0;
    style_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_served) begin
        holds_served = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(10, 80);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.data);
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cmd_item_t it;
    int        burst_left;
    burst_left = 0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Active open at the edges of the ranges, with the sequence numbers
    // wrapping through zero, then data, send, retransmit and a full close.
    it = make_request(ACT_OPEN); it.own_port = 16'd0; send_request(it);
    it = make_request(ACT_OPEN); it.far_port = 16'd0; send_request(it);
    it = make_request(ACT_OPEN);
    it.own_port = 16'hffff; it.far_port = 16'd1; it.initial_sequence = 32'hffff_ffff;
    send_request(it);
    it = make_request(ACT_RX_SYN_ACK); it.seg_ack ^= 32'h8000_0000; send_request(it);
    it = make_request(ACT_RX_SYN_ACK); it.seg_seq = 32'hffff_ffff; send_request(it);
    it = make_request(ACT_SET_WINDOW); it.length = 16'd0; send_request(it);
    it = make_request(ACT_RX_DATA); it.length = 16'd1; send_request(it);
    it = make_request(ACT_SET_WINDOW); it.length = WINDOW_FULL; send_request(it);
    it = make_request(ACT_RX_DATA); it.length = 16'hffff; send_request(it);
    it = make_request(ACT_SEND_DATA); it.length = 16'd0; send_request(it);
    it = make_request(ACT_SEND_DATA);
    it.length = 16'hffff; it.retx_cap = 8'hff;
    send_request(it);
    it = make_request(ACT_NOTE_RETX); send_request(it);
    it = make_request(ACT_COMMIT_SEND); it.length = 16'hffff; send_request(it);
    // An acknowledgment behind the send point while data is pending, then one
    // beyond it, then the exact one that clears the pending send.
    it = make_request(ACT_RX_ACK); it.seg_ack = sb.snd_nxt - 32'd1; send_request(it);
    it = make_request(ACT_RX_ACK); it.seg_ack = sb.snd_nxt + 32'd1; send_request(it);
    it = make_request(ACT_RX_ACK); send_request(it);
    it = make_request(ACT_TX_ACK); send_request(it);
    it = make_request(ACT_BEGIN_CLOSE); send_request(it);
    it = make_request(ACT_RX_ACK); send_request(it);
    it = make_request(ACT_RX_FIN); send_request(it);
    it = make_request(ACT_TX_ACK); it.action = 4'hf; send_request(it);
    // Passive open through to a close started by the peer.
    it = make_request(ACT_LISTEN); it.own_port = 16'd0; send_request(it);
    it = make_request(ACT_LISTEN); send_request(it);
    it = make_request(ACT_RX_SYN); it.seg_flags = FL_SYN | FL_ACK; send_request(it);
    it = make_request(ACT_RX_SYN); send_request(it);
    it = make_request(ACT_TX_SYN_ACK); send_request(it);
    it = make_request(ACT_RX_ACK); send_request(it);
    it = make_request(ACT_RX_FIN); send_request(it);
    drain_results();

    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      // Long receiver hold-off with the sender still pushing, and later a
      // pause until the block has handed back every result.
      if (k == 400) hold_asks++;
      if (k == 700) drain_results();
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                : $urandom_range(0, 4));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_request(random_request());
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d results, %0d with a built header.",
             sb.n_requests, sb.n_checked, sb.n_headers);
    $display("Connection states reached %b, status codes seen %b.", sb.states_seen,
             sb.statuses_seen);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
